/* src/kda_pkg.sv */
// kda_pkg: shared types, constants and key table for the key debounce block
// no dependencies
package kda_pkg;

  localparam int NUM_KEYS  = 12;
  localparam int KEY_W     = 4;
  localparam int TIME_W    = 48;
  localparam int INTV_W    = 24;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;
  localparam int WHITE_FIRST = 6;
  localparam logic [KEY_W-1:0] WHITE_OFFSET = 4'd6;

  // register index codes
  localparam logic [1:0] REG_VERSUS    = 2'd0;
  localparam logic [1:0] REG_DEBOUNCE  = 2'd1;
  localparam logic [1:0] REG_LONGPRESS = 2'd2;
  localparam logic [1:0] REG_REPEAT    = 2'd3;

  // reset values of the timing registers
  localparam logic [INTV_W-1:0] DEBOUNCE_RST  = 24'd25000;
  localparam logic [INTV_W-1:0] LONGPRESS_RST = 24'd180000;
  localparam logic [INTV_W-1:0] REPEAT_RST    = 24'd80000;

  typedef struct packed {
    logic [NUM_KEYS-1:0] raw_keys;
    logic [TIME_W-1:0]   now_us;
  } poll_word_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_code;
    logic [KEY_W-1:0] key_index;
    logic             is_repeat;
    logic             last;
  } evt_word_t;

  // timing settings shared by all lanes
  typedef struct packed {
    logic [INTV_W-1:0] debounce_us;
    logic [INTV_W-1:0] longpress_us;
    logic [INTV_W-1:0] repeat_us;
  } timing_cfg_t;

  // what one lane found for the current poll
  typedef struct packed {
    logic emit;
    logic is_repeat;
  } lane_evt_t;

  // base code per key: up,down,left,right,enter,back then up,down,right,left,enter,back
  function automatic logic [KEY_W-1:0] base_code(input logic [KEY_W-1:0] idx);
    logic [KEY_W-1:0] c;
    case (idx)
      4'd0:    c = 4'd0;
      4'd1:    c = 4'd1;
      4'd2:    c = 4'd2;
      4'd3:    c = 4'd3;
      4'd4:    c = 4'd4;
      4'd5:    c = 4'd5;
      4'd6:    c = 4'd0;
      4'd7:    c = 4'd1;
      4'd8:    c = 4'd3;
      4'd9:    c = 4'd2;
      4'd10:   c = 4'd4;
      4'd11:   c = 4'd5;
      default: c = 4'd0;
    endcase
    return c;
  endfunction

  // final code with the white-side shift in versus mode
  function automatic logic [KEY_W-1:0] code_for(input logic [KEY_W-1:0] idx,
                                                input logic versus);
    logic [KEY_W-1:0] c;
    c = base_code(idx);
    if (versus && (idx >= KEY_W'(WHITE_FIRST))) begin
      c = c + WHITE_OFFSET;
    end
    return c;
  endfunction

endpackage

/* src/kda_lane.sv */
// kda_lane: debounce and auto-repeat state and decision for one key
// depends on kda_pkg
module kda_lane
  import kda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic              raw,
  input  logic [TIME_W-1:0] now_us,
  input  timing_cfg_t       timing,
  output lane_evt_t         found
);

  logic              raw_seen;
  logic              debounced;
  logic [TIME_W-1:0] edge_time;
  logic [TIME_W-1:0] press_time;
  logic [TIME_W-1:0] repeat_time;

  logic              changed;
  logic [TIME_W-1:0] since_edge;
  logic [TIME_W-1:0] since_press;
  logic [TIME_W-1:0] since_repeat;
  logic              settled;
  logic              accept_level;
  logic              repeat_due;

  // elapsed times, each wrapping modulo 2^48
  assign changed      = raw != raw_seen;
  assign since_edge   = changed ? '0 : (now_us - edge_time);
  assign since_press  = now_us - press_time;
  assign since_repeat = now_us - repeat_time;

  assign settled      = since_edge >= {{(TIME_W-INTV_W){1'b0}}, timing.debounce_us};
  assign accept_level = settled && (raw != debounced);
  assign repeat_due   = settled && !accept_level && debounced && (press_time != '0)
                     && (since_press  >= {{(TIME_W-INTV_W){1'b0}}, timing.longpress_us})
                     && (since_repeat >= {{(TIME_W-INTV_W){1'b0}}, timing.repeat_us});

  // event for this poll
  always_comb begin
    found.emit      = (accept_level && raw) || repeat_due;
    found.is_repeat = repeat_due;
  end

  // key state update on poll accept
  always_ff @(posedge clk) begin
    if (rst) begin
      raw_seen    <= 1'b0;
      debounced   <= 1'b0;
      edge_time   <= '0;
      press_time  <= '0;
      repeat_time <= '0;
    end else if (load) begin
      if (changed) begin
        raw_seen  <= raw;
        edge_time <= now_us;
      end
      if (accept_level) begin
        debounced <= raw;
        if (raw) begin
          press_time  <= now_us;
          repeat_time <= now_us;
        end else begin
          press_time  <= '0;
          repeat_time <= '0;
        end
      end else if (repeat_due) begin
        repeat_time <= now_us;
      end
    end
  end

endmodule

/* src/kda_merge.sv */
// kda_merge: collects lane events and sends them out in key order with last flag
// depends on kda_pkg
module kda_merge
  import kda_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  lane_evt_t [NUM_KEYS-1:0] found,
  input  logic                 versus_mode,
  output logic                 busy,
  output logic                 evt_valid,
  input  logic                 evt_stall,
  output evt_word_t            evt
);

  logic [NUM_KEYS-1:0] pend;
  logic [NUM_KEYS-1:0] rep_mask;
  logic [NUM_KEYS-1:0] pick;
  logic [NUM_KEYS-1:0] rest;
  logic [KEY_W-1:0]    pick_idx;
  logic                take;

  // lowest pending key goes first
  assign pick = pend & (~pend + NUM_KEYS'(1));
  assign rest = pend & ~pick;

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (pick[i]) begin
        pick_idx = KEY_W'(i);
      end
    end
  end

  assign take = !evt_valid || !evt_stall;
  assign busy = pend != '0;

  // pending masks
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else if (load) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        pend[i] <= found[i].emit;
      end
    end else if (take) begin
      pend <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        rep_mask[i] <= found[i].emit && found[i].is_repeat;
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (take) begin
      evt_valid <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (take && busy) begin
      evt.key_code  <= code_for(pick_idx, versus_mode);
      evt.key_index <= pick_idx;
      evt.is_repeat <= rep_mask[pick_idx];
      evt.last      <= rest == '0;
    end
  end

  // a new poll only lands on an empty pending mask
  a_load_empty: assert property (@(posedge clk) disable iff (rst)
    load |-> pend == '0)
    else $error("poll loaded while events still pending");

  // a word marked last leaves nothing behind
  a_last_drains: assert property (@(posedge clk) disable iff (rst)
    (take && busy && rest == '0) |=> (evt_valid && evt.last && pend == '0))
    else $error("last flag does not match drained mask");

  // pending keys drain one a cycle when output is free
  a_drain_step: assert property (@(posedge clk) disable iff (rst)
    (busy && take && !load) |=> $countones(pend) == $countones($past(pend)) - 1)
    else $error("pending mask did not drop one key");

endmodule

/* src/key_debounce_autorepeat_unit.sv */
// key_debounce_autorepeat_unit: twelve lanes debounce all keys of a poll in parallel,
// then the merge stage sends one event word per cycle in key order while the event
// side does not stall. A poll's events load the pending mask, and the output word
// register takes them from it; poll_stall holds a new poll while any are pending.
// reset: rst clears all key state and restores the register reset values.
// depends on kda_pkg, kda_lane, kda_merge
module key_debounce_autorepeat_unit
  import kda_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // poll channel
  input  logic              poll_valid,
  output logic              poll_stall,
  input  poll_word_t        poll,
  // event channel
  output logic              evt_valid,
  input  logic              evt_stall,
  output evt_word_t         evt,
  // register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic        versus_mode;
  timing_cfg_t timing;
  logic        busy;
  logic        load;
  logic        reg_write;
  logic [1:0]  reg_sel;
  lane_evt_t [NUM_KEYS-1:0] found;

  assign pready    = 1'b1;
  assign reg_sel   = paddr[3:2];
  assign reg_write = psel && penable && pwrite && pready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      versus_mode         <= 1'b0;
      timing.debounce_us  <= DEBOUNCE_RST;
      timing.longpress_us <= LONGPRESS_RST;
      timing.repeat_us    <= REPEAT_RST;
    end else if (reg_write) begin
      case (reg_sel)
        REG_VERSUS:    versus_mode         <= pwdata[0];
        REG_DEBOUNCE:  timing.debounce_us  <= pwdata[INTV_W-1:0];
        REG_LONGPRESS: timing.longpress_us <= pwdata[INTV_W-1:0];
        REG_REPEAT:    timing.repeat_us    <= pwdata[INTV_W-1:0];
        default:       versus_mode         <= versus_mode;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      REG_VERSUS:    prdata = {{(DATA_W-1){1'b0}}, versus_mode};
      REG_DEBOUNCE:  prdata = {{(DATA_W-INTV_W){1'b0}}, timing.debounce_us};
      REG_LONGPRESS: prdata = {{(DATA_W-INTV_W){1'b0}}, timing.longpress_us};
      REG_REPEAT:    prdata = {{(DATA_W-INTV_W){1'b0}}, timing.repeat_us};
      default:       prdata = '0;
    endcase
  end

  // poll handshake
  assign poll_stall = busy;
  assign load       = poll_valid && !poll_stall;

  // one lane per key
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    kda_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .load   (load),
      .raw    (poll.raw_keys[k]),
      .now_us (poll.now_us),
      .timing (timing),
      .found  (found[k])
    );
  end

  // merge stage and output register
  kda_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .load        (load),
    .found       (found),
    .versus_mode (versus_mode),
    .busy        (busy),
    .evt_valid   (evt_valid),
    .evt_stall   (evt_stall),
    .evt         (evt)
  );

endmodule

/* test/key_debounce_autorepeat_unit_tb.sv */
// key_debounce_autorepeat_unit_tb: self-checking bench for the key debounce block,
// with a directed table, random polls under varied timing settings and idling.
// depends on kda_pkg and key_debounce_autorepeat_unit
module key_debounce_autorepeat_unit_tb;
  import kda_pkg::*;

  localparam int LIMIT_CYCLES  = 300000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_POLLS   = 30;
  // lands in the phase where neither side idles
  localparam int HOLD_AT       = 180;
  localparam int HOLD_CYCLES   = 400;
  localparam int NUM_ROWS      = 32;
  localparam logic [TIME_W-1:0] T_MAX = '1;
  // base code per key, key 0 in the low nibble
  localparam logic [4*NUM_KEYS-1:0] KEY_CODES = {4'd5, 4'd4, 4'd2, 4'd3, 4'd1, 4'd0,
                                                 4'd5, 4'd4, 4'd3, 4'd2, 4'd1, 4'd0};
  localparam evt_word_t NO_EVT = '0;

  typedef enum logic {ROW_POLL, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        reg_idx;
    logic [DATA_W-1:0] reg_val;
    poll_word_t        word;
    logic              chk;
    logic [3:0]        n;
    evt_word_t         first;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              poll_valid;
  logic              poll_stall;
  poll_word_t        poll;
  logic              evt_valid;
  logic              evt_stall;
  evt_word_t         evt;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // shadow settings and per-key state
  logic              cfg_versus;
  logic [INTV_W-1:0] cfg_debounce;
  logic [INTV_W-1:0] cfg_longpress;
  logic [INTV_W-1:0] cfg_repeat;
  logic              seen_raw [NUM_KEYS];
  logic              level    [NUM_KEYS];
  logic [TIME_W-1:0] edge_us  [NUM_KEYS];
  logic [TIME_W-1:0] press_us [NUM_KEYS];
  logic [TIME_W-1:0] rep_us   [NUM_KEYS];

  evt_word_t key_events_due [$];
  evt_word_t due_head;
  evt_word_t last_poll_first;
  int        last_poll_count;
  int        polls_seen = 0;
  int        mismatches = 0;
  int        cycle_count = 0;
  int        tx_idle_pct = 38;
  int        rx_idle_pct = 64;

  key_debounce_autorepeat_unit u_top (
    .clk        (clk),
    .rst        (rst),
    .poll_valid (poll_valid),
    .poll_stall (poll_stall),
    .poll       (poll),
    .evt_valid  (evt_valid),
    .evt_stall  (evt_stall),
    .evt        (evt),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // code, index and repeat flag of one key event
  function automatic evt_word_t make_event(input int idx, input logic rep);
    evt_word_t ev;
    ev.key_code = KEY_CODES[4*idx +: KEY_W];
    if (cfg_versus && idx >= WHITE_FIRST) begin
      ev.key_code = ev.key_code + WHITE_OFFSET;
    end
    ev.key_index = KEY_W'(idx);
    ev.is_repeat = rep;
    ev.last      = 1'b0;
    return ev;
  endfunction

  // debounce one poll across all keys and queue the events it causes
  function automatic void scan_keys(input poll_word_t w);
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] since_edge;
    logic [TIME_W-1:0] since_press;
    logic [TIME_W-1:0] since_rep;
    logic              raw;
    evt_word_t         ev;
    evt_word_t         batch [$];
    now = w.now_us;
    for (int i = 0; i < NUM_KEYS; i++) begin
      raw = w.raw_keys[i];
      if (raw != seen_raw[i]) begin
        seen_raw[i] = raw;
        edge_us[i]  = now;
      end
      since_edge = now - edge_us[i];
      if (since_edge >= TIME_W'(cfg_debounce)) begin
        if (raw != level[i]) begin
          // accepted change: a press reports, a release only clears the timers
          level[i]    = raw;
          press_us[i] = raw ? now : '0;
          rep_us[i]   = raw ? now : '0;
          if (raw) batch.push_back(make_event(i, 1'b0));
        end else if (level[i] && press_us[i] != '0) begin
          since_press = now - press_us[i];
          since_rep   = now - rep_us[i];
          if (since_press >= TIME_W'(cfg_longpress) && since_rep >= TIME_W'(cfg_repeat)) begin
            rep_us[i] = now;
            batch.push_back(make_event(i, 1'b1));
          end
        end
      end
    end
    last_poll_count = batch.size();
    foreach (batch[k]) begin
      ev      = batch[k];
      ev.last = (k == batch.size() - 1);
      if (k == 0) last_poll_first = ev;
      key_events_due.push_back(ev);
    end
  endfunction

  function automatic dir_row_t poll_row(input logic [NUM_KEYS-1:0] raw,
                                        input logic [TIME_W-1:0] now, input logic chk,
                                        input logic [3:0] n, input evt_word_t first);
    dir_row_t r;
    r = '0;
    r.kind           = ROW_POLL;
    r.word.raw_keys  = raw;
    r.word.now_us    = now;
    r.chk            = chk;
    r.n              = n;
    r.first          = first;
    return r;
  endfunction

  function automatic dir_row_t reg_row(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    dir_row_t r;
    r = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // directed polls: debounce and long-press edges, press at time zero,
  // wrap of the timestamp, versus codes, register extremes and masking
  dir_row_t directed [NUM_ROWS] = '{
    poll_row(12'h000, 48'd0,            1'b1, 4'd0,  NO_EVT),
    poll_row(12'hFFF, 48'd0,            1'b1, 4'd0,  NO_EVT),
    poll_row(12'hFFF, 48'd24999,        1'b1, 4'd0,  NO_EVT),
    poll_row(12'hFFF, 48'd25000,        1'b1, 4'd12, {4'd0, 4'd0, 1'b0, 1'b0}),
    poll_row(12'hFFF, 48'd204999,       1'b1, 4'd0,  NO_EVT),
    poll_row(12'hFFF, 48'd205000,       1'b1, 4'd12, {4'd0, 4'd0, 1'b1, 1'b0}),
    poll_row(12'hFFF, 48'd285000,       1'b0, 4'd0,  NO_EVT),
    poll_row(12'hFFF, 48'd300000,       1'b1, 4'd0,  NO_EVT),
    poll_row(12'h000, 48'd310000,       1'b1, 4'd0,  NO_EVT),
    poll_row(12'h000, 48'd335000,       1'b1, 4'd0,  NO_EVT),
    poll_row(12'h001, T_MAX - 48'd24999, 1'b1, 4'd0, NO_EVT),
    poll_row(12'h001, 48'd0,            1'b1, 4'd1,  {4'd0, 4'd0, 1'b0, 1'b1}),
    poll_row(12'h001, 48'd400000,       1'b1, 4'd0,  NO_EVT),
    poll_row(12'h801, 48'd400000,       1'b0, 4'd0,  NO_EVT),
    poll_row(12'h801, 48'd425000,       1'b1, 4'd1,  {4'd5, 4'd11, 1'b0, 1'b1}),
    poll_row(12'h000, 48'd450000,       1'b0, 4'd0,  NO_EVT),
    poll_row(12'h000, 48'd475000,       1'b0, 4'd0,  NO_EVT),
    poll_row(12'h010, T_MAX - 48'd99999, 1'b1, 4'd0, NO_EVT),
    poll_row(12'h010, T_MAX - 48'd74999, 1'b1, 4'd1, {4'd4, 4'd4, 1'b0, 1'b1}),
    poll_row(12'h010, 48'd105000,       1'b1, 4'd1,  {4'd4, 4'd4, 1'b1, 1'b1}),
    reg_row(REG_VERSUS,    32'hFFFF_FFFF),
    reg_row(REG_DEBOUNCE,  32'hFF00_0000),
    reg_row(REG_LONGPRESS, 32'd0),
    reg_row(REG_REPEAT,    32'd0),
    poll_row(12'hFC0, 48'd1000,         1'b1, 4'd6,  {4'd6, 4'd6, 1'b0, 1'b0}),
    poll_row(12'hFC0, 48'd1001,         1'b1, 4'd6,  {4'd6, 4'd6, 1'b1, 1'b0}),
    reg_row(REG_DEBOUNCE,  32'h00FF_FFFF),
    reg_row(REG_LONGPRESS, 32'h00FF_FFFF),
    reg_row(REG_REPEAT,    32'h00FF_FFFF),
    poll_row(12'h03F, 48'd2000,         1'b1, 4'd0,  NO_EVT),
    poll_row(12'h03F, 48'd16779215,     1'b1, 4'd6,  {4'd0, 4'd0, 1'b0, 1'b0}),
    poll_row(12'h03F, 48'd33556430,     1'b0, 4'd0,  NO_EVT)
  };

  // offer one poll word, with random idle cycles ahead of it
  task automatic send_poll(input poll_word_t w);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      poll_valid = 1'b0;
      @(negedge clk);
    end
    poll_valid = 1'b1;
    poll       = w;
    @(posedge clk);
    while (poll_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and let the block drain before touching registers
  task automatic wait_quiet();
    poll_valid = 1'b0;
    while (key_events_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write followed by a read back of the stored value
  task automatic reg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] stored;
    stored = '0;
    case (idx)
      REG_VERSUS: begin
        cfg_versus = value[0];
        stored     = DATA_W'(value[0]);
      end
      REG_DEBOUNCE: begin
        cfg_debounce = value[INTV_W-1:0];
        stored       = DATA_W'(value[INTV_W-1:0]);
      end
      REG_LONGPRESS: begin
        cfg_longpress = value[INTV_W-1:0];
        stored        = DATA_W'(value[INTV_W-1:0]);
      end
      default: begin
        cfg_repeat = value[INTV_W-1:0];
        stored     = DATA_W'(value[INTV_W-1:0]);
      end
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    psel    = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata !== stored) begin
      $display("%0t: register %0d read back expected %h, got %h", $time, idx, stored, prdata);
      mismatches++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic apply_timing(input logic versus, input logic [INTV_W-1:0] deb,
                              input logic [INTV_W-1:0] lp, input logic [INTV_W-1:0] rep);
    reg_write(REG_VERSUS,    DATA_W'(versus));
    reg_write(REG_DEBOUNCE,  DATA_W'(deb));
    reg_write(REG_LONGPRESS, DATA_W'(lp));
    reg_write(REG_REPEAT,    DATA_W'(rep));
  endtask

  // predict on every accepted poll word
  always @(posedge clk) begin
    if (!rst && poll_valid && !poll_stall) begin
      scan_keys(poll);
      polls_seen++;
    end
  end

  // compare every accepted event word with the oldest prediction
  always @(posedge clk) begin
    if (!rst && evt_valid && !evt_stall) begin
      if (key_events_due.size() == 0) begin
        $display("%0t: event word with none expected: code %0d index %0d repeat %0b last %0b",
                 $time, evt.key_code, evt.key_index, evt.is_repeat, evt.last);
        mismatches++;
      end else begin
        due_head = key_events_due.pop_front();
        if (evt.key_code !== due_head.key_code) begin
          $display("%0t: key_code expected %0d, got %0d", $time, due_head.key_code, evt.key_code);
          mismatches++;
        end
        if (evt.key_index !== due_head.key_index) begin
          $display("%0t: key_index expected %0d, got %0d", $time, due_head.key_index,
                   evt.key_index);
          mismatches++;
        end
        if (evt.is_repeat !== due_head.is_repeat) begin
          $display("%0t: is_repeat expected %0b, got %0b", $time, due_head.is_repeat,
                   evt.is_repeat);
          mismatches++;
        end
        if (evt.last !== due_head.last) begin
          $display("%0t: last expected %0b, got %0b", $time, due_head.last, evt.last);
          mismatches++;
        end
      end
    end
  end

  // event side stall, with one long hold-off so the block backs up
  initial begin : event_sink
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    evt_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && polls_seen >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        evt_stall = 1'b1;
        hold_left--;
      end else begin
        evt_stall = ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("key_debounce_autorepeat_unit_tb: FAIL");
    $finish;
  end

  initial begin : main_seq
    poll_word_t          w;
    logic [NUM_KEYS-1:0] held;
    logic [NUM_KEYS-1:0] raw;
    logic [TIME_W-1:0]   clock_us;
    int                  pick;
    int                  scale;
    rst           = 1'b1;
    poll_valid    = 1'b0;
    poll          = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    cfg_versus    = 1'b0;
    cfg_debounce  = DEBOUNCE_RST;
    cfg_longpress = LONGPRESS_RST;
    cfg_repeat    = REPEAT_RST;
    for (int i = 0; i < NUM_KEYS; i++) begin
      seen_raw[i] = 1'b0;
      level[i]    = 1'b0;
      edge_us[i]  = '0;
      press_us[i] = '0;
      rep_us[i]   = '0;
    end
    repeat (8) @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (directed[r].kind == ROW_REG) begin
        wait_quiet();
        reg_write(directed[r].reg_idx, directed[r].reg_val);
      end else begin
        send_poll(directed[r].word);
        if (directed[r].chk) begin
          if (last_poll_count != directed[r].n) begin
            $display("%0t: row %0d expected %0d events, predicted %0d", $time, r,
                     directed[r].n, last_poll_count);
            mismatches++;
          end else if (last_poll_count > 0 && last_poll_first !== directed[r].first) begin
            $display("%0t: row %0d expected first event %h, predicted %h", $time, r,
                     directed[r].first, last_poll_first);
            mismatches++;
          end
        end
      end
    end

    // random polls: mostly held maps over advancing time, some bounce and jumps
    held     = '0;
    clock_us = 48'd100;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_quiet();
      if (ph < 2) begin
        tx_idle_pct = 38;
        rx_idle_pct = 64;
      end else if (ph < 4) begin
        tx_idle_pct = 64;
        rx_idle_pct = 38;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      case (ph)
        0: apply_timing(1'b0, DEBOUNCE_RST, LONGPRESS_RST, REPEAT_RST);
        1: apply_timing(1'b1, 24'd1000, 24'd5000, 24'd2000);
        2: apply_timing(1'b0, 24'd0, 24'd0, 24'd0);
        3: apply_timing(1'b1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        4: apply_timing(1'($urandom_range(0, 1)), 24'($urandom_range(0, 40000)),
                        24'($urandom_range(0, 200000)), 24'($urandom_range(0, 100000)));
        default: begin
          // start just short of the wrap
          apply_timing(1'b1, 24'd300, 24'd3000, 24'd1000);
          clock_us = T_MAX - TIME_W'($urandom_range(0, 20000));
        end
      endcase
      scale = int'(cfg_debounce) + int'(cfg_repeat) / 2 + 1;
      for (int k = 0; k < PHASE_POLLS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 15) begin
          held = held ^ (12'd1 << $urandom_range(0, NUM_KEYS - 1));
        end else if (pick < 20) begin
          held = 12'($urandom);
        end
        raw = held;
        if ($urandom_range(0, 99) < 10) raw = held ^ 12'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 78) begin
          clock_us = clock_us + TIME_W'($urandom_range(0, scale));
        end else if (pick < 84) begin
          clock_us = clock_us + TIME_W'($urandom_range(0, 4 * (int'(cfg_longpress) + 1)));
        end else if (pick < 86) begin
          clock_us = '0;
        end else if (pick < 88) begin
          clock_us = TIME_W'({$urandom, $urandom});
        end
        w.raw_keys = raw;
        w.now_us   = clock_us;
        send_poll(w);
      end
    end

    wait_quiet();
    if (mismatches == 0 && key_events_due.size() == 0) begin
      $display("key_debounce_autorepeat_unit_tb: PASS");
    end else begin
      $display("key_debounce_autorepeat_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
